// ----- src/int8_activation_requantizer_macros.svh -----
// ----------------------------------------------------------------------------
// int8 activation requantizer assertion macros
// Shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef INT8_ACTIVATION_REQUANTIZER_MACROS_SVH
`define INT8_ACTIVATION_REQUANTIZER_MACROS_SVH

// Check that is switched off while reset is held.
`define IAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds through reset.
`define IAR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/iar_pkg.sv -----
// ----------------------------------------------------------------------------
// iar_pkg
// Types, constants and the requantize function shared by the requantizer.
// ----------------------------------------------------------------------------
package iar_pkg;

  localparam int ACC_W      = 32;
  localparam int SCALE_W    = 16;
  localparam int ZERO_W     = 8;
  localparam int OUT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QBITS      = 9;
  localparam int DIV_W      = 32;
  localparam int DIV_STAGES = 10;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd128;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_RELU     = 3'd1,
    MODE_RELU6    = 3'd2,
    MODE_LEAKY    = 3'd3,
    MODE_SIGMOID  = 3'd4,
    MODE_TANH     = 3'd5,
    MODE_SWISH    = 3'd6,
    MODE_ALT_NONE = 3'd7
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_SCALE = 2'd1,
    REG_ZERO  = 2'd2
  } reg_idx_t;

  // Saturated quotient magnitude with its sign and a divide-by-zero flag.
  typedef struct packed {
    logic [QBITS-1:0] q;
    logic             neg;
    logic             dz;
  } quot_t;

  // Data that rides along with an item through the dividers.
  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic                    big;
    logic signed [OUT_W-1:0] r1;
  } side_t;

  // Signed quotient plus zero point, saturated to int8.
  function automatic logic signed [OUT_W-1:0] requant(quot_t qt,
                                                      logic signed [ZERO_W-1:0] z);
    logic signed [QBITS+1:0] qs;
    logic signed [QBITS+2:0] sum;
    logic signed [OUT_W-1:0] res;
    qs = qt.neg ? -$signed({2'b00, qt.q}) : $signed({2'b00, qt.q});
    if (qt.dz) begin
      qs = '0;
    end
    sum = $signed({qs[QBITS+1], qs}) + $signed({{(QBITS+3-ZERO_W){z[ZERO_W-1]}}, z});
    if (sum > 12'sd127) begin
      res = 8'sd127;
    end else if (sum < -12'sd128) begin
      res = -8'sd128;
    end else begin
      res = sum[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- src/iar_intf.sv -----
// ----------------------------------------------------------------------------
// iar channel interfaces
// Valid/ready channels for accumulators, results and register writes.
// ----------------------------------------------------------------------------
interface iar_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [iar_pkg::ACC_W-1:0]  acc_value;
  modport source (output valid, output acc_value, input ready);
  modport sink   (input valid, input acc_value, output ready);
endinterface

interface iar_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [iar_pkg::OUT_W-1:0]  act_out;
  modport source (output valid, output act_out, input ready);
  modport sink   (input valid, input act_out, output ready);
endinterface

interface iar_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [iar_pkg::CFG_IDX_W-1:0]      index;
  logic [iar_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/int8_activation_requantizer.sv -----
// ----------------------------------------------------------------------------
// int8_activation_requantizer
// Activation and requantization of 32-bit accumulators to int8.
//
//   channel   dir   handshake     payload
//   in_ch     in    valid/ready   acc_value  (signed 32)
//   out_ch    out   valid/ready   act_out    (signed 8)
//   cfg_ch    in    valid/ready   index (2), data (16)
//
// One word is taken per cycle unless the pipeline holds; its result passes two
// ten-stage dividers in series before it reaches the output register.
// Reset is synchronous and clears valid bits and the registers to defaults.
// The pipeline holds only when its last stage has a word and the output
// register still holds an untaken word; every stage then holds together.
// Register writes are always taken.
// ----------------------------------------------------------------------------
module int8_activation_requantizer (
  input  logic clk,
  input  logic rst_n,
  iar_in_if.sink    in_ch,
  iar_out_if.source out_ch,
  iar_cfg_if.sink   cfg_ch
);
  import iar_pkg::*;

  mode_t                    mode_r;
  logic [SCALE_W-1:0]       scale_r;
  logic signed [ZERO_W-1:0] zero_r;

  logic                     ce;
  logic                     f_v, d1_v, m_v, d2_v;
  logic signed [ACC_W-1:0]  f_a, m_a;
  logic [DIV_W-1:0]         m_d;
  side_t                    f_side, d1_side, m_side, d2_side;
  quot_t                    d1_q, d2_q;

  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NONE;
      scale_r <= SCALE_RESET;
      zero_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MODE:  mode_r  <= mode_t'(cfg_ch.data[2:0]);
        REG_SCALE: scale_r <= cfg_ch.data[SCALE_W-1:0];
        REG_ZERO:  zero_r  <= cfg_ch.data[ZERO_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  assign ce          = !(d2_v && out_valid_r && !out_ch.ready);
  assign in_ch.ready = ce;

  iar_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .v_i    (in_ch.valid),
    .x_i    (in_ch.acc_value),
    .mode   (mode_r),
    .scale  (scale_r),
    .v_o    (f_v),
    .a_o    (f_a),
    .side_o (f_side)
  );

  iar_div u_div1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .v_i    (f_v),
    .a_i    (f_a),
    .d_i    ({{(DIV_W-SCALE_W){1'b0}}, scale_r}),
    .side_i (f_side),
    .v_o    (d1_v),
    .q_o    (d1_q),
    .side_o (d1_side)
  );

  iar_mid u_mid (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .v_i    (d1_v),
    .q_i    (d1_q),
    .side_i (d1_side),
    .mode   (mode_r),
    .scale  (scale_r),
    .zero   (zero_r),
    .v_o    (m_v),
    .a_o    (m_a),
    .d_o    (m_d),
    .side_o (m_side)
  );

  iar_div u_div2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .v_i    (m_v),
    .a_i    (m_a),
    .d_i    (m_d),
    .side_i (m_side),
    .v_o    (d2_v),
    .q_o    (d2_q),
    .side_o (d2_side)
  );

  always_comb begin
    if (mode_r == MODE_TANH || mode_r == MODE_SWISH) begin
      out_nxt = requant(d2_q, zero_r);
    end else begin
      out_nxt = d2_side.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce && d2_v) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce && d2_v) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.act_out = out_r;

endmodule

// ----- src/iar_front.sv -----
// ----------------------------------------------------------------------------
// iar_front
// Two stages: activation for the simple modes, sigmoid segment select and
// the dividend that goes into the first divider.
// ----------------------------------------------------------------------------
module iar_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ce,
  input  logic                             v_i,
  input  logic signed [iar_pkg::ACC_W-1:0] x_i,
  input  iar_pkg::mode_t                   mode,
  input  logic [iar_pkg::SCALE_W-1:0]      scale,
  output logic                             v_o,
  output logic signed [iar_pkg::ACC_W-1:0] a_o,
  output iar_pkg::side_t                   side_o
);
  import iar_pkg::*;

  logic                    v1_r, v2_r;
  logic signed [ACC_W-1:0] x1_r, xs1_r;
  logic signed [ACC_W-1:0] x1_nxt, xs1_nxt;
  logic signed [ACC_W-1:0] a2_r, a2_nxt;
  side_t                   side2_r, side2_nxt;

  logic [ACC_W:0]          mag;
  logic [ACC_W:0]          s4, s2;
  logic                    big, mid, spos, xpos;
  logic signed [ACC_W-1:0] quarter, half, sig_d;
  logic [SCALE_W+2:0]      six;

  always_comb begin
    x1_nxt  = x_i;
    xs1_nxt = (mode == MODE_TANH) ? (x_i <<< 1) : x_i;
  end

  always_comb begin
    // Magnitude at 33 bits so that the most negative value counts as large.
    mag  = xs1_r[ACC_W-1] ? ((ACC_W+1)'(0) - {xs1_r[ACC_W-1], xs1_r}) : {1'b0, xs1_r};
    s4   = {{(ACC_W-SCALE_W-1){1'b0}}, scale, 2'b00};
    s2   = {{(ACC_W-SCALE_W){1'b0}}, scale, 1'b0};
    big  = mag > s4;
    mid  = mag > s2;
    spos = !xs1_r[ACC_W-1] && (xs1_r != '0);
    xpos = !x1_r[ACC_W-1] && (x1_r != '0);
    quarter = xs1_r >>> 2;
    half    = $signed({{(ACC_W-SCALE_W+1){1'b0}}, scale[SCALE_W-1:1]});
    sig_d   = (mid && !spos) ? (quarter - half) : (quarter + half);
    six     = {1'b0, scale, 2'b00} + {2'b00, scale, 1'b0};

    side2_nxt.x   = x1_r;
    side2_nxt.big = 1'b0;
    side2_nxt.r1  = spos ? 8'sd127 : -8'sd128;

    unique case (mode)
      MODE_RELU: begin
        a2_nxt = xpos ? x1_r : '0;
      end
      MODE_RELU6: begin
        if (!xpos) begin
          a2_nxt = '0;
        end else if (x1_r < $signed({{(ACC_W-SCALE_W-3){1'b0}}, six})) begin
          a2_nxt = x1_r;
        end else begin
          a2_nxt = $signed({{(ACC_W-SCALE_W-3){1'b0}}, six});
        end
      end
      MODE_LEAKY: begin
        a2_nxt = xpos ? x1_r : (x1_r >>> 4);
      end
      MODE_SIGMOID, MODE_TANH, MODE_SWISH: begin
        a2_nxt        = sig_d;
        side2_nxt.big = big;
      end
      default: begin
        a2_nxt = x1_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ce) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x1_r    <= x1_nxt;
      xs1_r   <= xs1_nxt;
      a2_r    <= a2_nxt;
      side2_r <= side2_nxt;
    end
  end

  assign v_o    = v2_r;
  assign a_o    = a2_r;
  assign side_o = side2_r;

endmodule

// ----- src/iar_div.sv -----
// ----------------------------------------------------------------------------
// iar_div
// Pipelined signed divider that returns the quotient truncated toward zero,
// with its magnitude saturated to the nine bits that requantization needs.
// ----------------------------------------------------------------------------
module iar_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             ce,
  input  logic                             v_i,
  input  logic signed [iar_pkg::ACC_W-1:0] a_i,
  input  logic [iar_pkg::DIV_W-1:0]        d_i,
  input  iar_pkg::side_t                   side_i,
  output logic                             v_o,
  output iar_pkg::quot_t                   q_o,
  output iar_pkg::side_t                   side_o
);
  import iar_pkg::*;

  localparam int LAST = DIV_STAGES - 1;
  localparam int WIDE = DIV_W + QBITS + 1;

  logic [DIV_STAGES-1:0]  v_r;
  logic [ACC_W-1:0]       rem_r   [DIV_STAGES];
  logic [ACC_W-1:0]       rem_nxt [DIV_STAGES];
  logic [QBITS-1:0]       q_r     [DIV_STAGES];
  logic [QBITS-1:0]       q_nxt   [DIV_STAGES];
  logic [DIV_W-1:0]       d_r     [DIV_STAGES];
  logic [DIV_W-1:0]       d_nxt   [DIV_STAGES];
  logic                   sat_r   [DIV_STAGES];
  logic                   sat_nxt [DIV_STAGES];
  logic                   neg_r   [DIV_STAGES];
  logic                   neg_nxt [DIV_STAGES];
  side_t                  side_r  [DIV_STAGES];
  side_t                  side_nxt[DIV_STAGES];

  logic [WIDE-1:0]        rem_w, sub_w;
  logic                   ge;

  always_comb begin
    rem_nxt[0]  = a_i[ACC_W-1] ? ACC_W'(-a_i) : a_i;
    q_nxt[0]    = '0;
    d_nxt[0]    = d_i;
    sat_nxt[0]  = 1'b0;
    neg_nxt[0]  = a_i[ACC_W-1];
    side_nxt[0] = side_i;
    rem_w = '0;
    sub_w = '0;
    ge    = 1'b0;
    // One quotient bit per stage, most significant first.
    for (int k = 1; k < DIV_STAGES; k++) begin
      rem_w = {{(WIDE-ACC_W){1'b0}}, rem_r[k-1]};
      sub_w = {{(WIDE-DIV_W){1'b0}}, d_r[k-1]} << (DIV_STAGES - 1 - k);
      ge    = rem_w >= sub_w;
      rem_nxt[k] = ge ? ACC_W'(rem_w - sub_w) : rem_r[k-1];
      q_nxt[k]   = q_r[k-1];
      q_nxt[k][DIV_STAGES-1-k] = ge;
      d_nxt[k]   = d_r[k-1];
      neg_nxt[k] = neg_r[k-1];
      side_nxt[k] = side_r[k-1];
      if (k == 1) begin
        sat_nxt[k] = rem_w >= ({{(WIDE-DIV_W){1'b0}}, d_r[0]} << QBITS);
      end else begin
        sat_nxt[k] = sat_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[DIV_STAGES-2:0], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        q_r[k]    <= q_nxt[k];
        d_r[k]    <= d_nxt[k];
        sat_r[k]  <= sat_nxt[k];
        neg_r[k]  <= neg_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign v_o    = v_r[LAST];
  assign q_o.q  = sat_r[LAST] ? {QBITS{1'b1}} : q_r[LAST];
  assign q_o.neg = neg_r[LAST];
  assign q_o.dz = (d_r[LAST] == '0);
  assign side_o = side_r[LAST];

endmodule

// ----- src/iar_mid.sv -----
// ----------------------------------------------------------------------------
// iar_mid
// Requantizes the first quotient, then forms the second dividend and
// divisor for tanh (2*sig - scale over scale) and swish (x*sig over scale^2).
// ----------------------------------------------------------------------------
module iar_mid (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ce,
  input  logic                              v_i,
  input  iar_pkg::quot_t                    q_i,
  input  iar_pkg::side_t                    side_i,
  input  iar_pkg::mode_t                    mode,
  input  logic [iar_pkg::SCALE_W-1:0]       scale,
  input  logic signed [iar_pkg::ZERO_W-1:0] zero,
  output logic                              v_o,
  output logic signed [iar_pkg::ACC_W-1:0]  a_o,
  output logic [iar_pkg::DIV_W-1:0]         d_o,
  output iar_pkg::side_t                    side_o
);
  import iar_pkg::*;

  logic                      va_r, vb_r;
  logic signed [ACC_W-1:0]   xa_r;
  logic signed [OUT_W-1:0]   r1a_r, r1a_nxt;
  logic signed [ACC_W-1:0]   ab_r, ab_nxt;
  logic [DIV_W-1:0]          db_r, db_nxt;
  side_t                     sideb_r, sideb_nxt;

  logic signed [ACC_W+OUT_W-1:0] prod;
  logic signed [ACC_W-1:0]       tanh_d;
  logic [DIV_W-1:0]              sq;

  always_comb begin
    r1a_nxt = side_i.big ? side_i.r1 : requant(q_i, zero);
  end

  always_comb begin
    prod   = xa_r * r1a_r;
    tanh_d = $signed({{(ACC_W-OUT_W-1){r1a_r[OUT_W-1]}}, r1a_r, 1'b0})
           - $signed({{(ACC_W-SCALE_W){1'b0}}, scale});
    sq     = scale * scale;
    // Two truncating divisions by scale equal one by scale squared.
    if (mode == MODE_SWISH) begin
      ab_nxt = prod[ACC_W-1:0];
      db_nxt = sq;
    end else begin
      ab_nxt = tanh_d;
      db_nxt = {{(DIV_W-SCALE_W){1'b0}}, scale};
    end
    sideb_nxt.x   = xa_r;
    sideb_nxt.big = 1'b0;
    sideb_nxt.r1  = r1a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (ce) begin
      va_r <= v_i;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xa_r    <= side_i.x;
      r1a_r   <= r1a_nxt;
      ab_r    <= ab_nxt;
      db_r    <= db_nxt;
      sideb_r <= sideb_nxt;
    end
  end

  assign v_o    = vb_r;
  assign a_o    = ab_r;
  assign d_o    = db_r;
  assign side_o = sideb_r;

endmodule

// ----- src/iar_checker.sv -----
// ----------------------------------------------------------------------------
// iar_checker
// Port-level checks on the requantizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "int8_activation_requantizer_macros.svh"

module iar_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [iar_pkg::OUT_W-1:0] act_out,
  input logic cfg_ready
);

  // A result that was not taken stays put.
  `IAR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(act_out), "result word changed while stalled")

  // Reset empties the output register.
  `IAR_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "output valid after reset")

  // With an empty output register the pipeline never holds.
  `IAR_ASSERT(a_in_free, !out_valid |-> in_ready, "input held with empty output")

  // Register writes are never refused.
  `IAR_ASSERT(a_cfg_ready, cfg_ready, "register write refused")

endmodule

bind int8_activation_requantizer iar_checker u_iar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .act_out   (out_ch.act_out),
  .cfg_ready (cfg_ch.ready)
);

// ----- dv/int8_activation_requantizer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_activation_requantizer_checker
// Watches the register, accumulator and result channels. It keeps its own copy
// of the registers, predicts each int8 result and compares it with the output.
// ----------------------------------------------------------------------------
module int8_activation_requantizer_checker (
  input  logic clk,
  input  logic rst_n,
  iar_in_if    in_ch,
  iar_out_if   out_ch,
  iar_cfg_if   cfg_ch,
  output int   fails,
  output int   pending
);
  import iar_pkg::*;

  mode_t                    cur_mode;
  logic [SCALE_W-1:0]       cur_scale;
  logic signed [ZERO_W-1:0] cur_zero;
  logic signed [OUT_W-1:0]  expected_acts[$];

  function automatic longint to_s32(longint v);
    logic [31:0] low;
    low = v[31:0];
    return longint'($signed(low));
  endfunction

  function automatic longint div_scale(longint a);
    longint s;
    s = longint'(cur_scale);
    return (s == 0) ? 0 : a / s;
  endfunction

  function automatic longint quantize(longint a);
    longint r;
    r = div_scale(a) + longint'(cur_zero);
    if (r > 127) return 127;
    if (r < -128) return -128;
    return r;
  endfunction

  function automatic longint sigmoid_int8(longint x);
    longint mag;
    longint s;
    longint half;
    mag  = (x < 0) ? -x : x;
    s    = longint'(cur_scale);
    half = s / 2;
    // Beyond four units the curve is flat and the zero point is not applied.
    if (mag > 4 * s) return (x > 0) ? 127 : -128;
    if (mag > 2 * s) return quantize(to_s32((x >>> 2) + ((x > 0) ? half : -half)));
    return quantize(to_s32((x >>> 2) + half));
  endfunction

  function automatic logic signed [OUT_W-1:0] activate(logic signed [ACC_W-1:0] acc);
    longint x;
    longint s;
    longint sg;
    longint r;
    x = longint'(acc);
    s = longint'(cur_scale);
    case (cur_mode)
      MODE_RELU: begin
        r = quantize((x > 0) ? x : 0);
      end
      MODE_RELU6: begin
        r = quantize((x > 0) ? ((x < 6 * s) ? x : 6 * s) : 0);
      end
      MODE_LEAKY: begin
        r = quantize((x > 0) ? x : (x >>> 4));
      end
      MODE_SIGMOID: begin
        r = sigmoid_int8(x);
      end
      MODE_TANH: begin
        sg = sigmoid_int8(to_s32(x * 2));
        r  = quantize(to_s32(2 * sg - s));
      end
      MODE_SWISH: begin
        sg = sigmoid_int8(x);
        r  = quantize(div_scale(to_s32(x * sg)));
      end
      default: begin
        r = quantize(x);
      end
    endcase
    return r[OUT_W-1:0];
  endfunction

  assign pending = expected_acts.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode  <= MODE_NONE;
      cur_scale <= SCALE_RESET;
      cur_zero  <= '0;
      fails     <= 0;
      expected_acts.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_acts = {expected_acts, activate(in_ch.acc_value)};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_acts.size() == 0) begin
          $error("act_out: unexpected word, actual %0d", out_ch.act_out);
          fails <= fails + 1;
        end else if (expected_acts[0] !== out_ch.act_out) begin
          $error("act_out mismatch: expected %0d, actual %0d", expected_acts[0],
                 out_ch.act_out);
          fails <= fails + 1;
          void'(expected_acts.pop_front());
        end else begin
          void'(expected_acts.pop_front());
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (reg_idx_t'(cfg_ch.index))
          REG_MODE:  cur_mode  <= mode_t'(cfg_ch.data[2:0]);
          REG_SCALE: cur_scale <= cfg_ch.data[SCALE_W-1:0];
          REG_ZERO:  cur_zero  <= cfg_ch.data[ZERO_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- dv/int8_activation_requantizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_activation_requantizer_tb
// Drives accumulators through every activation mode and several register
// settings, with random idling on both channels; a checker compares results.
// ----------------------------------------------------------------------------
module int8_activation_requantizer_tb;
  import iar_pkg::*;

  localparam int LIMIT  = 600000;
  localparam int SETTLE = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fails;
  int   pending;
  int   cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic [SCALE_W-1:0] scale_now;

  iar_in_if  in_ch();
  iar_out_if out_ch();
  iar_cfg_if cfg_ch();

  int8_activation_requantizer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  int8_activation_requantizer_checker i_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(input mode_t m, input logic [SCALE_W-1:0] s,
                       input logic signed [ZERO_W-1:0] z);
    write_reg(REG_MODE, {13'($urandom), m});
    write_reg(REG_SCALE, s);
    write_reg(REG_ZERO, {8'($urandom), z});
    scale_now = s;
  endtask

  task automatic send_acc(input logic signed [ACC_W-1:0] v);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.acc_value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Lowers valid and lets the pipeline empty before any register changes.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [ACC_W-1:0] pick_acc();
    longint s;
    longint k;
    s = longint'(scale_now);
    k = longint'($urandom_range(0, 7)) * s + longint'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 5))
      0: return $signed(32'($urandom));
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return 32'($urandom_range(0, 1) ? k : -k);
      3: return 32'($signed(12'($urandom)));
      default: return 32'(longint'($urandom_range(0, 20 * s + 40)) - 10 * s - 20);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hffff;
      3: return 16'($urandom);
      default: return 16'($urandom_range(2, 300));
    endcase
  endfunction

  function automatic logic signed [ZERO_W-1:0] pick_zero();
    case ($urandom_range(0, 3))
      0: return -8'sd128;
      1: return 8'sd127;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.acc_value  = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_MODE;
    cfg_ch.data      = '0;
    scale_now        = SCALE_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults first, then each mode at the extremes and a breakpoint.
    send_acc(32'sh7fffffff);
    drain();
    for (int m = 0; m < 8; m++) begin
      setup(mode_t'(m), 16'd16, (m % 2) ? 8'sd127 : -8'sd128);
      send_acc(32'sh80000000);
      send_acc(32'sh7fffffff);
      send_acc((m == int'(MODE_RELU6)) ? 32'sd96 : -32'sd65);
      drain();
    end

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 77 : (phase == 3) ? 36 : 0;
      stall_pct = (phase == 2) ? 77 : (phase == 3) ? 36 : 0;
      for (int set = 0; set < 5; set++) begin
        setup(mode_t'($urandom_range(0, 7)), pick_scale(), pick_zero());
        for (int n = 0; n < 50; n++) begin
          send_acc(pick_acc());
        end
        drain();
      end
    end

    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
